### sv/text_mode_terminal_writer_top_defines.svh
// Assertion helpers for the text terminal writer RTL.
// Each macro expects clk_i and rst_ni in the scope of use.
`ifndef TEXT_MODE_TERMINAL_WRITER_TOP_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define TMTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TMTW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define TMTW_ASSERT(lbl, prop, msg)

`define TMTW_NEVER(lbl, cond, msg)

`endif

`endif

### sv/tmtw_pkg.sv
package tmtw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned SCR_W  = 6;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned LIN_W  = 11;
  localparam int unsigned SRC_W  = LIN_W + 2;
  localparam int unsigned CELL_W = CHAR_W + ATTR_W;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h1F;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'd0;

  localparam logic signed [SRC_W-1:0] SRC_CELLS = SRC_W'(CELLS);

  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_SCROLL = 3'd2,
    OP_READ   = 3'd3,
    OP_SETCUR = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CHAR,
    CMD_LF,
    CMD_CR,
    CMD_CLEAR,
    CMD_SCROLL,
    CMD_READ,
    CMD_SETCUR
  } cmd_kind_e;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_SWEEP,
    EX_PUT,
    EX_READ
  } exec_state_e;

  // One classified command word as it sits in the queue.
  typedef struct packed {
    cmd_kind_e         kind;
    logic [CHAR_W-1:0] ch;
    logic              up;
    logic [LIN_W-1:0]  offset;
    logic [LIN_W-1:0]  idx;
    logic              idx_ok;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### sv/tmtw_ram.sv
module tmtw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/tmtw_front.sv
module tmtw_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [tmtw_pkg::OP_W-1:0]        opcode_i,
  input  logic [tmtw_pkg::CHAR_W-1:0]      char_code_i,
  input  logic signed [tmtw_pkg::SCR_W-1:0] scroll_lines_i,
  input  logic [tmtw_pkg::LIN_W-1:0]       cell_index_i,
  input  logic [tmtw_pkg::COL_W-1:0]       new_col_i,
  input  logic [tmtw_pkg::ROW_W-1:0]       new_row_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tmtw_pkg::ATTR_W-1:0]      cfg_text_attribute_i,
  input  tmtw_pkg::fifo_stat_t             fifo_stat_i,
  output logic                             push_o,
  output tmtw_pkg::cmd_t                   cmd_o,
  output logic [tmtw_pkg::ATTR_W-1:0]      attr_o
);

  logic [tmtw_pkg::ATTR_W-1:0] attr_q;
  logic [tmtw_pkg::SCR_W-1:0]  mag;
  logic [tmtw_pkg::ROW_W-1:0]  mag_c;

  assign busy_o      = fifo_stat_i.full;
  assign push_o      = start_i && !fifo_stat_i.full;
  assign cfg_ready_o = 1'b1;
  assign attr_o      = attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tmtw_pkg::ATTR_RESET;
    end else if (cfg_valid_i) begin
      attr_q <= cfg_text_attribute_i;
    end
  end

  // scroll magnitude, clamped to a full screen
  always_comb begin
    mag   = scroll_lines_i[tmtw_pkg::SCR_W-1] ? tmtw_pkg::SCR_W'(-scroll_lines_i)
                                              : tmtw_pkg::SCR_W'(scroll_lines_i);
    mag_c = (mag >= tmtw_pkg::SCR_W'(tmtw_pkg::ROWS)) ? tmtw_pkg::ROW_W'(tmtw_pkg::ROWS)
                                                      : tmtw_pkg::ROW_W'(mag);
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.kind   = tmtw_pkg::CMD_NOP;
    cmd_o.ch     = char_code_i;
    cmd_o.up     = !scroll_lines_i[tmtw_pkg::SCR_W-1];
    cmd_o.offset = tmtw_pkg::LIN_W'(mag_c) * tmtw_pkg::LIN_W'(tmtw_pkg::COLUMNS);
    cmd_o.idx    = cell_index_i;
    cmd_o.idx_ok = cell_index_i < tmtw_pkg::LIN_W'(tmtw_pkg::CELLS);
    cmd_o.col    = (new_col_i > tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS))
                   ? tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS) : new_col_i;
    cmd_o.row    = (new_row_i > tmtw_pkg::ROW_W'(tmtw_pkg::ROWS - 1))
                   ? tmtw_pkg::ROW_W'(tmtw_pkg::ROWS - 1) : new_row_i;
    case (tmtw_pkg::opcode_e'(opcode_i))
      tmtw_pkg::OP_PUT: begin
        if (char_code_i == tmtw_pkg::CHAR_LF) begin
          cmd_o.kind = tmtw_pkg::CMD_LF;
        end else if (char_code_i == tmtw_pkg::CHAR_CR) begin
          cmd_o.kind = tmtw_pkg::CMD_CR;
        end else begin
          cmd_o.kind = tmtw_pkg::CMD_CHAR;
        end
      end
      tmtw_pkg::OP_CLEAR:  cmd_o.kind = tmtw_pkg::CMD_CLEAR;
      tmtw_pkg::OP_SCROLL: cmd_o.kind = tmtw_pkg::CMD_SCROLL;
      tmtw_pkg::OP_READ:   cmd_o.kind = tmtw_pkg::CMD_READ;
      tmtw_pkg::OP_SETCUR: cmd_o.kind = tmtw_pkg::CMD_SETCUR;
      default:             cmd_o.kind = tmtw_pkg::CMD_NOP;
    endcase
  end

endmodule

### sv/tmtw_cmd_fifo.sv
module tmtw_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tmtw_pkg::cmd_t       cmd_i,
  input  logic                 pop_i,
  output tmtw_pkg::cmd_t       cmd_o,
  output tmtw_pkg::fifo_stat_t stat_o
);

  tmtw_pkg::cmd_t                  mem_q [tmtw_pkg::FIFO_DEPTH];
  logic [tmtw_pkg::FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [tmtw_pkg::FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [tmtw_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign stat_o.full  = (cnt_q == tmtw_pkg::FIFO_CNT_W'(tmtw_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == tmtw_pkg::FIFO_PTR_W'(tmtw_pkg::FIFO_DEPTH - 1))
               ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == tmtw_pkg::FIFO_PTR_W'(tmtw_pkg::FIFO_DEPTH - 1))
               ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

### sv/tmtw_back.sv
`include "text_mode_terminal_writer_top_defines.svh"

module tmtw_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tmtw_pkg::fifo_stat_t        fifo_stat_i,
  input  tmtw_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  input  logic [tmtw_pkg::ATTR_W-1:0] attr_i,
  output logic                        res_valid_o,
  output logic [tmtw_pkg::CHAR_W-1:0] res_char_o,
  output logic [tmtw_pkg::ATTR_W-1:0] res_attr_o,
  output logic [tmtw_pkg::COL_W-1:0]  res_col_o,
  output logic [tmtw_pkg::ROW_W-1:0]  res_row_o,
  output logic [tmtw_pkg::LIN_W-1:0]  res_lin_o
);

  tmtw_pkg::exec_state_e state_q, state_d;

  logic [tmtw_pkg::COL_W-1:0]        col_q, col_d;
  logic [tmtw_pkg::ROW_W-1:0]        row_q, row_d;
  logic [tmtw_pkg::CHAR_W-1:0]       ch_q, ch_d;
  logic                              pend_q, pend_d;
  logic [tmtw_pkg::LIN_W-1:0]        cnt_q, cnt_d;
  logic [tmtw_pkg::LIN_W-1:0]        dst_q, dst_d;
  logic signed [tmtw_pkg::SRC_W-1:0] src_q, src_d;
  logic                              up_q, up_d;
  logic                              blank_all_q, blank_all_d;

  // copy pipeline: read issued one cycle, write the next
  logic                              p_valid_q;
  logic [tmtw_pkg::LIN_W-1:0]        p_dst_q;
  logic                              p_blank_q;

  logic                              res_valid_q;
  logic [tmtw_pkg::CHAR_W-1:0]       res_char_q;
  logic [tmtw_pkg::ATTR_W-1:0]       res_attr_q;
  logic [tmtw_pkg::COL_W-1:0]        res_col_q;
  logic [tmtw_pkg::ROW_W-1:0]        res_row_q;
  logic [tmtw_pkg::LIN_W-1:0]        res_lin_q;

  logic                              sw_start, sw_up, sw_blank_all;
  logic [tmtw_pkg::LIN_W-1:0]        sw_off;

  logic                              last_row, sweep_done, issue, src_blank;
  logic                              emit;
  logic [tmtw_pkg::CHAR_W-1:0]       emit_char;
  logic [tmtw_pkg::ATTR_W-1:0]       emit_attr;
  logic [tmtw_pkg::LIN_W-1:0]        emit_lin, put_addr;

  logic                              ram_we;
  logic [tmtw_pkg::LIN_W-1:0]        ram_waddr, ram_raddr;
  logic [tmtw_pkg::CELL_W-1:0]       ram_wdata, ram_rdata;

  assign last_row   = (row_q == tmtw_pkg::ROW_W'(tmtw_pkg::ROWS - 1));
  assign sweep_done = (cnt_q == tmtw_pkg::LIN_W'(tmtw_pkg::CELLS));
  assign put_addr   = tmtw_pkg::LIN_W'(row_q) * tmtw_pkg::LIN_W'(tmtw_pkg::COLUMNS)
                      + tmtw_pkg::LIN_W'(col_q);

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    ch_d         = ch_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    dst_d        = dst_q;
    src_d        = src_q;
    up_d         = up_q;
    blank_all_d  = blank_all_q;
    sw_start     = 1'b0;
    sw_up        = 1'b1;
    sw_off       = tmtw_pkg::LIN_W'(tmtw_pkg::COLUMNS);
    sw_blank_all = 1'b0;
    case (state_q)
      tmtw_pkg::EX_IDLE: begin
        if (!fifo_stat_i.empty) begin
          case (cmd_i.kind)
            tmtw_pkg::CMD_CHAR: begin
              ch_d    = cmd_i.ch;
              state_d = tmtw_pkg::EX_PUT;
              if (col_q >= tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS)) begin
                col_d = '0;
                if (last_row) begin
                  sw_start = 1'b1;
                  pend_d   = 1'b1;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end
            end
            tmtw_pkg::CMD_LF: begin
              col_d = '0;
              if (last_row) begin
                sw_start = 1'b1;
                pend_d   = 1'b0;
              end else begin
                row_d = row_q + 1'b1;
              end
            end
            tmtw_pkg::CMD_CR: col_d = '0;
            tmtw_pkg::CMD_CLEAR: begin
              col_d        = '0;
              row_d        = '0;
              sw_start     = 1'b1;
              sw_blank_all = 1'b1;
              pend_d       = 1'b0;
            end
            tmtw_pkg::CMD_SCROLL: begin
              sw_start = 1'b1;
              sw_up    = cmd_i.up;
              sw_off   = cmd_i.offset;
              pend_d   = 1'b0;
            end
            tmtw_pkg::CMD_READ: begin
              if (cmd_i.idx_ok) begin
                state_d = tmtw_pkg::EX_READ;
              end
            end
            tmtw_pkg::CMD_SETCUR: begin
              col_d = cmd_i.col;
              row_d = cmd_i.row;
            end
            default: ;
          endcase
        end
      end
      tmtw_pkg::EX_SWEEP: begin
        if (sweep_done) begin
          state_d = pend_q ? tmtw_pkg::EX_PUT : tmtw_pkg::EX_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
          dst_d = up_q ? dst_q + 1'b1 : dst_q - 1'b1;
          src_d = up_q ? src_q + tmtw_pkg::SRC_W'(1) : src_q - tmtw_pkg::SRC_W'(1);
        end
      end
      tmtw_pkg::EX_PUT: begin
        col_d   = col_q + 1'b1;
        state_d = tmtw_pkg::EX_IDLE;
      end
      tmtw_pkg::EX_READ: state_d = tmtw_pkg::EX_IDLE;
      default:           state_d = tmtw_pkg::EX_IDLE;
    endcase
    // upward walks start at the top row, downward ones at the bottom
    if (sw_start) begin
      state_d     = tmtw_pkg::EX_SWEEP;
      cnt_d       = '0;
      up_d        = sw_up;
      blank_all_d = sw_blank_all;
      dst_d       = sw_up ? '0 : tmtw_pkg::LIN_W'(tmtw_pkg::CELLS - 1);
      src_d       = sw_up ? $signed({2'b00, sw_off})
                          : tmtw_pkg::SRC_W'(tmtw_pkg::CELLS - 1) - $signed({2'b00, sw_off});
    end
  end

  // outputs: queue pop, memory control, result word
  always_comb begin
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_char = '0;
    emit_attr = '0;
    issue     = 1'b0;
    ram_raddr = src_q[tmtw_pkg::LIN_W-1:0];
    src_blank = blank_all_q || (up_q ? (src_q >= tmtw_pkg::SRC_CELLS) : (src_q < 0));
    case (state_q)
      tmtw_pkg::EX_IDLE: begin
        ram_raddr = cmd_i.idx;
        if (!fifo_stat_i.empty) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            tmtw_pkg::CMD_LF:     emit = !last_row;
            tmtw_pkg::CMD_CR:     emit = 1'b1;
            tmtw_pkg::CMD_READ:   emit = !cmd_i.idx_ok;
            tmtw_pkg::CMD_SETCUR: emit = 1'b1;
            tmtw_pkg::CMD_NOP:    emit = 1'b1;
            default:              emit = 1'b0;
          endcase
        end
      end
      tmtw_pkg::EX_SWEEP: begin
        issue = !sweep_done;
        emit  = sweep_done && !pend_q;
      end
      tmtw_pkg::EX_PUT: emit = 1'b1;
      tmtw_pkg::EX_READ: begin
        emit      = 1'b1;
        emit_char = ram_rdata[tmtw_pkg::CELL_W-1:tmtw_pkg::ATTR_W];
        emit_attr = ram_rdata[tmtw_pkg::ATTR_W-1:0];
      end
      default: ;
    endcase
    ram_we    = p_valid_q || (state_q == tmtw_pkg::EX_PUT);
    ram_waddr = p_valid_q ? p_dst_q : put_addr;
    if (p_valid_q) begin
      ram_wdata = p_blank_q ? {tmtw_pkg::CHAR_BLANK, attr_i} : ram_rdata;
    end else begin
      ram_wdata = {ch_q, attr_i};
    end
    emit_lin = tmtw_pkg::LIN_W'(row_d) * tmtw_pkg::LIN_W'(tmtw_pkg::COLUMNS)
               + tmtw_pkg::LIN_W'(col_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmtw_pkg::EX_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      pend_q      <= 1'b0;
      p_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pend_q      <= pend_d;
      p_valid_q   <= issue;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q        <= ch_d;
    cnt_q       <= cnt_d;
    dst_q       <= dst_d;
    src_q       <= src_d;
    up_q        <= up_d;
    blank_all_q <= blank_all_d;
    p_dst_q     <= dst_q;
    p_blank_q   <= src_blank;
    if (emit) begin
      res_char_q <= emit_char;
      res_attr_q <= emit_attr;
      res_col_q  <= col_d;
      res_row_q  <= row_d;
      res_lin_q  <= emit_lin;
    end
  end

  tmtw_ram #(
    .WIDTH (tmtw_pkg::CELL_W),
    .DEPTH (tmtw_pkg::CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o = res_valid_q;
  assign res_char_o  = res_char_q;
  assign res_attr_o  = res_attr_q;
  assign res_col_o   = res_col_q;
  assign res_row_o   = res_row_q;
  assign res_lin_o   = res_lin_q;

  `TMTW_NEVER(a_waddr_range, ram_we && (ram_waddr >= tmtw_pkg::LIN_W'(tmtw_pkg::CELLS)), "cell write out of range")
  `TMTW_NEVER(a_put_col, (state_q == tmtw_pkg::EX_PUT) && (col_q >= tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS)), "char write past last column")
  `TMTW_NEVER(a_row_range, row_q >= tmtw_pkg::ROW_W'(tmtw_pkg::ROWS), "cursor row out of range")
  `TMTW_ASSERT(a_read_done, (state_q == tmtw_pkg::EX_READ) |=> (res_valid_q && (state_q == tmtw_pkg::EX_IDLE)), "read did not complete")
  `TMTW_ASSERT(a_sweep_emit, ((state_q == tmtw_pkg::EX_SWEEP) && sweep_done && !pend_q) |=> res_valid_q, "walk ended without result")

endmodule

### sv/text_mode_terminal_writer_top.sv
// Text-mode terminal writer: an 80x25 screen of character/attribute cells plus a cursor.
// Command channel: a word is taken on a clock edge with start_i high and busy_o low.
// Each command gives exactly one result word, shown for one cycle with result_valid_o.
// The result path never stalls: the receiver must take every word when the strobe is up.
// Config channel: cfg_text_attribute_i is written when cfg_valid_i and cfg_ready_o are
// high; cfg_ready_o is always high. Write it only with no command outstanding.
// A two-word command queue splits the classifier from the execution engine, so busy_o
// rises only when the queue is full.
// From accept to strobe, CR, LF without scroll, set cursor, unused opcodes and
// out-of-range reads pass the queue and the result register; a character or a cell
// read also passes the put or read state. Clear, scroll, LF on the last row and a
// character that wraps off the last row walk all 2000 cells through the one RAM write
// port, each read issued ahead of its write. The walk length sets the worst case rate.
// Reset homes the cursor and loads attribute 0x1F; cell contents stay undefined
// until a clear command runs.
module text_mode_terminal_writer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command channel
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [tmtw_pkg::OP_W-1:0]        opcode_i,
  input  logic [tmtw_pkg::CHAR_W-1:0]      char_code_i,
  input  logic signed [tmtw_pkg::SCR_W-1:0] scroll_lines_i,
  input  logic [tmtw_pkg::LIN_W-1:0]       cell_index_i,
  input  logic [tmtw_pkg::COL_W-1:0]       new_col_i,
  input  logic [tmtw_pkg::ROW_W-1:0]       new_row_i,
  // attribute register write
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tmtw_pkg::ATTR_W-1:0]      cfg_text_attribute_i,
  // result words
  output logic                             result_valid_o,
  output logic [tmtw_pkg::CHAR_W-1:0]      read_char_o,
  output logic [tmtw_pkg::ATTR_W-1:0]      read_attr_o,
  output logic [tmtw_pkg::COL_W-1:0]       cursor_col_o,
  output logic [tmtw_pkg::ROW_W-1:0]       cursor_row_o,
  output logic [tmtw_pkg::LIN_W-1:0]       cursor_linear_o
);

  tmtw_pkg::cmd_t              push_cmd, head_cmd;
  tmtw_pkg::fifo_stat_t        fifo_stat;
  logic                        push, pop;
  logic [tmtw_pkg::ATTR_W-1:0] attr;

  // front: handshake, attribute register, opcode decode and clamping
  tmtw_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .opcode_i             (opcode_i),
    .char_code_i          (char_code_i),
    .scroll_lines_i       (scroll_lines_i),
    .cell_index_i         (cell_index_i),
    .new_col_i            (new_col_i),
    .new_row_i            (new_row_i),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_text_attribute_i (cfg_text_attribute_i),
    .fifo_stat_i          (fifo_stat),
    .push_o               (push),
    .cmd_o                (push_cmd),
    .attr_o               (attr)
  );

  // decoupling queue between decode and execution
  tmtw_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (fifo_stat)
  );

  // back: cursor, cell RAM, copy/clear walker, result register
  tmtw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .attr_i      (attr),
    .res_valid_o (result_valid_o),
    .res_char_o  (read_char_o),
    .res_attr_o  (read_attr_o),
    .res_col_o   (cursor_col_o),
    .res_row_o   (cursor_row_o),
    .res_lin_o   (cursor_linear_o)
  );

endmodule
